// ===== hw/rtl/siq_pkg.sv =====
package siq_pkg;

  localparam int unsigned OpWidth     = 2;
  localparam int unsigned InKeyWidth  = 32;
  localparam int unsigned IndexWidth  = 4;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned PosWidth    = 5;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned OutKeyWidth = 32;

  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 48;

  typedef enum logic [OpWidth-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic CFG_SIGNED_KEYS = 1'b0;
  localparam logic CFG_DESCENDING  = 1'b1;

  // shared control broadcast to every cell
  typedef struct packed {
    logic shift_en;
    logic signed_keys;
    logic descending;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sorted_insertion_queue.sv =====
// Channel   | Dir | Beat contents
// s_axis    | in  | op, key, index
// m_axis    | out | status, position, count, read_key
// cfg       | in  | signed_keys (index 0), descending_order (index 1)
//
// One beat per cycle unless the output stalls: every cell compares the incoming key
// against its own entry in the same cycle, so the whole shift register row moves at once.
// The result sits in an output register; a new beat is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset clears the entry count and the settings; entries themselves are not
// cleared and read as nothing until written.
module sorted_insertion_queue import siq_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // [1:0] op, [33:2] key, [37:34] index, [39:38] zero
  input  logic [InDataWidth-1:0]  s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // [1:0] status, [6:2] position, [11:7] count, [43:12] read_key, [47:44] zero
  output logic [OutDataWidth-1:0] m_axis_tdata_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic                    cfg_data_i
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned RD_N = (DEPTH < 16) ? DEPTH : 16;

  logic                   signed_q, desc_q;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q;
  logic [StatusWidth-1:0] out_status_q;
  logic [PosWidth-1:0]    out_pos_q;
  logic [CountWidth-1:0]  out_count_q;
  logic [OutKeyWidth-1:0] out_key_q;

  op_e                    op;
  logic [InKeyWidth-1:0]  key_in;
  logic [IndexWidth-1:0]  idx_in;
  logic [63:0]            key_ext;
  logic [KEY_WIDTH-1:0]   key_st;
  logic                   acc, full, shift_req;
  cell_ctrl_t             ctrl;

  logic [KEY_WIDTH-1:0]   entry [DEPTH];
  logic [DEPTH-1:0]       gt;
  logic [DEPTH-1:0]       occ;

  status_e                status_d;
  logic [PosWidth-1:0]    pos_d;
  logic [OutKeyWidth-1:0] rkey_d;
  logic [31:0]            ins_pos;
  logic [KEY_WIDTH-1:0]   rd_entry;
  logic [63:0]            rd_ext;
  logic [31:0]            count_ext;

  assign op      = op_e'(s_axis_tdata_i[1:0]);
  assign key_in  = s_axis_tdata_i[33:2];
  assign idx_in  = s_axis_tdata_i[37:34];
  assign key_ext = 64'(key_in);
  assign key_st  = key_ext[KEY_WIDTH-1:0];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign full = (count_q == CW'(DEPTH));

  assign ctrl.shift_en    = acc && shift_req;
  assign ctrl.signed_keys = signed_q;
  assign ctrl.descending  = desc_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count_q > CW'(i));
    if (i == 0) begin : g_head
      siq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occupied_i (occ[i]),
        .prev_gt_i  (1'b1),
        .prev_key_i (key_st),
        .key_i      (key_st),
        .gt_o       (gt[i]),
        .entry_o    (entry[i])
      );
    end else begin : g_body
      siq_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occupied_i (occ[i]),
        .prev_gt_i  (gt[i-1]),
        .prev_key_i (entry[i-1]),
        .key_i      (key_st),
        .gt_o       (gt[i]),
        .entry_o    (entry[i])
      );
    end
  end

  // gt is a prefix; the insert point is where it drops
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (((i == 0) || gt[(i == 0) ? 0 : i-1]) && !gt[i]) begin
        ins_pos = ins_pos | 32'(i);
      end
    end
  end

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (idx_in == IndexWidth'(i)) begin
        rd_entry = entry[i];
      end
    end
  end
  assign rd_ext = 64'(rd_entry);

  always_comb begin
    status_d  = ST_DONE;
    pos_d     = '0;
    rkey_d    = '0;
    count_d   = count_q;
    shift_req = 1'b0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          shift_req = 1'b1;
          count_d   = CW'(count_q + 1'b1);
          pos_d     = ins_pos[PosWidth-1:0];
        end
      end
      OP_READ: begin
        pos_d = PosWidth'(idx_in);
        if (32'(idx_in) < 32'(count_q)) begin
          rkey_d = rd_ext[OutKeyWidth-1:0];
        end else begin
          status_d = ST_BAD_INDEX;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q    <= 1'b0;
      desc_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SIGNED_KEYS) begin
          signed_q <= cfg_data_i;
        end else begin
          desc_q <= cfg_data_i;
        end
      end
      if (acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_status_q <= status_d;
      out_pos_q    <= pos_d;
      out_count_q  <= count_ext[CountWidth-1:0];
      out_key_q    <= rkey_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_key_q, out_count_q, out_pos_q, out_status_q};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_gt_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gt[DEPTH-1:1] & ~gt[DEPTH-2:0]) == '0)
    else $error("compare vector is not a prefix");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op == OP_INSERT && !full) |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("insert did not grow the list");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op == OP_INSERT && full) |=> count_q == CW'(DEPTH))
    else $error("rejected insert changed the count");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> m_axis_tvalid_o)
    else $error("accepted beat left no result");
`endif

endmodule

// ===== hw/rtl/siq_cell.sv =====
module siq_cell import siq_pkg::*; #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 occupied_i,
  input  logic                 prev_gt_i,
  input  logic [KEY_WIDTH-1:0] prev_key_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  output logic                 gt_o,
  output logic [KEY_WIDTH-1:0] entry_o
);

  localparam logic [KEY_WIDTH-1:0] SignBit = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  logic [KEY_WIDTH-1:0] entry_q, entry_d;
  logic [KEY_WIDTH-1:0] a, b;
  logic                 after;

  // bias the sign bit so an unsigned compare orders two's complement keys
  assign a = key_i   ^ (ctrl_i.signed_keys ? SignBit : '0);
  assign b = entry_q ^ (ctrl_i.signed_keys ? SignBit : '0);
  assign after = ctrl_i.descending ? (a < b) : (a > b);
  // flag ripples from the head: the first cell that does not pass stops the row,
  // even when the held order no longer matches the current settings
  assign gt_o = prev_gt_i & occupied_i & after;

  // cells ahead of the insert point keep, the boundary cell takes the key,
  // cells behind it take their left neighbor
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_en && !gt_o) begin
      entry_d = prev_gt_i ? key_i : prev_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== tb/tb_sorted_insertion_queue.sv =====
module tb_sorted_insertion_queue;
  import siq_pkg::*;

  localparam int unsigned ListDepth  = 16;
  localparam int unsigned PhaseItems = 125;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned CycleLimit = 200000;
  // op code the block must ignore
  localparam logic [OpWidth-1:0] OpUnused = 2'd3;

  // same layout as the low bits of m_axis_tdata_o
  typedef struct packed {
    logic [OutKeyWidth-1:0] read_key;
    logic [CountWidth-1:0]  count;
    logic [PosWidth-1:0]    position;
    logic [StatusWidth-1:0] status;
  } siq_result_t;

  typedef struct {
    logic [OpWidth-1:0]    op;
    logic [InKeyWidth-1:0] key;
    logic [IndexWidth-1:0] index;
    bit                    fixed;
    siq_result_t           want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    s_valid;
  logic                    s_ready;
  logic [InDataWidth-1:0]  s_data;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OutDataWidth-1:0] m_data;
  logic                    cfg_we;
  logic                    cfg_idx;
  logic                    cfg_data;

  siq_result_t           pending_results[$];
  stim_row_t             directed_rows[$];
  logic [InKeyWidth-1:0] held_keys[ListDepth];
  logic [CountWidth-1:0] held_count;
  logic                  cfg_signed;
  logic                  cfg_desc;
  int unsigned           fails;
  int unsigned           burst_left;
  int unsigned           stall_mode;
  int unsigned           stall_left;
  int unsigned           stall_tick;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  sorted_insertion_queue u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // true when key a has to stay behind key b
  function automatic bit sorts_behind(logic [InKeyWidth-1:0] a, logic [InKeyWidth-1:0] b);
    logic [InKeyWidth-1:0] x;
    logic [InKeyWidth-1:0] y;
    x = a;
    y = b;
    if (cfg_signed) begin
      x[InKeyWidth-1] = ~x[InKeyWidth-1];
      y[InKeyWidth-1] = ~y[InKeyWidth-1];
    end
    return cfg_desc ? (x < y) : (x > y);
  endfunction

  function automatic siq_result_t list_step(logic [OpWidth-1:0] op, logic [InKeyWidth-1:0] key,
                                           logic [IndexWidth-1:0] index);
    siq_result_t res;
    int          pos;
    res = '0;
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (held_count >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          while (pos < held_count && sorts_behind(key, held_keys[pos])) pos++;
          for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = key;
          held_count++;
          res.position = PosWidth'(pos);
        end
      end
      OP_READ: begin
        res.position = PosWidth'(index);
        if (index < held_count) res.read_key = held_keys[index];
        else res.status = ST_BAD_INDEX;
      end
      OP_CLEAR: begin
        held_count = '0;
      end
      default: ;
    endcase
    res.count = held_count;
    return res;
  endfunction

  function automatic void add_row(logic [OpWidth-1:0] op, logic [InKeyWidth-1:0] key,
                                  logic [IndexWidth-1:0] index, bit fixed,
                                  logic [StatusWidth-1:0] status, logic [PosWidth-1:0] position,
                                  logic [CountWidth-1:0] count, logic [OutKeyWidth-1:0] read_key);
    stim_row_t row;
    row.op            = op;
    row.key           = key;
    row.index         = index;
    row.fixed         = fixed;
    row.want.status   = status;
    row.want.position = position;
    row.want.count    = count;
    row.want.read_key = read_key;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    logic [InKeyWidth-1:0] fill_keys[12] = '{
      32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0001,
      32'h1234_5678, 32'hDEAD_BEEF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0};
    // empty list after reset
    add_row(OP_READ,   32'hFFFF_FFFF, 4'd0,  1, ST_BAD_INDEX, 5'd0,  5'd0, '0);
    add_row(OP_READ,   32'h0000_0000, 4'd15, 1, ST_BAD_INDEX, 5'd15, 5'd0, '0);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 4'd15, 1, ST_DONE,      5'd0,  5'd1, '0);
    add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1, ST_DONE,      5'd0,  5'd2, '0);
    add_row(OP_INSERT, 32'h8000_0000, 4'd5,  0, ST_DONE,      '0,    '0,   '0);
    // equal key lands ahead of the one already held
    add_row(OP_INSERT, 32'h8000_0000, 4'd10, 0, ST_DONE,      '0,    '0,   '0);
    add_row(OP_READ,   32'h5A5A_5A5A, 4'd1,  0, ST_DONE,      '0,    '0,   '0);
    add_row(OP_READ,   32'hA5A5_A5A5, 4'd3,  0, ST_DONE,      '0,    '0,   '0);
    add_row(OP_READ,   32'h0000_0000, 4'd4,  1, ST_BAD_INDEX, 5'd4,  5'd4, '0);
    add_row(OpUnused,  32'hA5A5_A5A5, 4'd15, 1, ST_DONE,      5'd0,  5'd4, '0);
    foreach (fill_keys[i]) begin
      add_row(OP_INSERT, fill_keys[i], 4'(i), 0, ST_DONE, '0, '0, '0);
    end
    add_row(OP_INSERT, 32'h0000_0002, 4'd9,  1, ST_FULL,      5'd0,  5'd16, '0);
    add_row(OP_READ,   32'hFFFF_FFFF, 4'd15, 0, ST_DONE,      '0,    '0,    '0);
    add_row(OP_CLEAR,  32'hFFFF_FFFF, 4'd15, 1, ST_DONE,      5'd0,  5'd0,  '0);
  endfunction

  function automatic logic [InKeyWidth-1:0] pick_key();
    logic [InKeyWidth-1:0] corner_keys[4] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    case ($urandom_range(0, 9))
      0:       return corner_keys[$urandom_range(0, 3)];
      1, 2, 3: return $urandom_range(0, 7);      // small keys, lots of ties
      4:       return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t random_row(int unsigned ins_weight);
    stim_row_t   row;
    int unsigned r;
    row.fixed = 0;
    row.want  = '0;
    row.key   = $urandom;
    row.index = IndexWidth'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 3) begin
      row.op = OP_CLEAR;
    end else if (r < 5) begin
      row.op = OpUnused;
    end else if (r < 5 + ins_weight) begin
      row.op  = OP_INSERT;
      row.key = pick_key();
    end else begin
      row.op = OP_READ;
      if (held_count != 0 && $urandom_range(0, 3) != 0) begin
        row.index = IndexWidth'($urandom_range(0, held_count - 1));
      end
    end
    return row;
  endfunction

  task automatic drive_beat(input stim_row_t row);
    siq_result_t predicted;
    @(negedge clk);
    s_valid <= 1'b1;
    s_data  <= {2'b00, row.index, row.key, row.op};
    do @(posedge clk); while (!s_ready);
    predicted = list_step(row.op, row.key, row.index);
    pending_results.push_back(row.fixed ? row.want : predicted);
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // drop valid and hold off until the last result beat is out
  task automatic settle();
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input logic idx, input logic val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SIGNED_KEYS) cfg_signed = val;
    else cfg_desc = val;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= 1'($urandom_range(0, 1));
      2:       m_ready <= ($urandom_range(0, 3) == 0);
      default: m_ready <= (stall_tick % 3 == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    siq_result_t got;
    siq_result_t want;
    if (rst_n && m_valid && m_ready) begin
      got = m_data[$bits(siq_result_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: 0x%0h", got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",   32'(want.status),   32'(got.status));
        check_field("position", 32'(want.position), 32'(got.position));
        check_field("count",    32'(want.count),    32'(got.count));
        check_field("read_key", want.read_key, got.read_key);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    int unsigned ins_weight;
    logic [1:0]  setting;
    s_valid    = 1'b0;
    s_data     = '0;
    cfg_we     = 1'b0;
    cfg_idx    = 1'b0;
    cfg_data   = 1'b0;
    rst_n      = 1'b0;
    fails      = 0;
    burst_left = 0;
    held_count = '0;
    cfg_signed = 1'b0;
    cfg_desc   = 1'b0;
    build_directed();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      drive_beat(directed_rows[i]);
      pace_sender();
    end

    // first four phases walk every setting, the rest pick at random
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      setting = (p < 4) ? p[1:0] : 2'($urandom_range(0, 3));
      write_setting(CFG_SIGNED_KEYS, setting[0]);
      write_setting(CFG_DESCENDING, setting[1]);
      ins_weight = $urandom_range(45, 75);
      repeat (PhaseItems) begin
        row = random_row(ins_weight);
        drive_beat(row);
        pace_sender();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/siq_pkg.sv
hw/rtl/siq_cell.sv
hw/rtl/sorted_insertion_queue.sv
tb/tb_sorted_insertion_queue.sv
